// ===== design/swz_pkg.sv =====
// ----------------------------------------------------------------------------
// swz_pkg: shared types and constants
// Widths and codes for the sliding window z-score detector.
// ----------------------------------------------------------------------------
package swz_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int NUM_METRICS = 4;
  localparam int SAMPLE_W    = 24;

  localparam int POS_W   = $clog2(WINDOW_MAX);
  localparam int WIN_W   = POS_W + 1;
  localparam int CH_W    = 2;
  localparam int SUM_W   = SAMPLE_W + POS_W;
  localparam int SQ_W    = 2 * SAMPLE_W + POS_W;
  localparam int SENS_W  = 16;
  localparam int SENS2_W = 2 * SENS_W;
  localparam int NQ_W    = WIN_W + SQ_W;
  localparam int SS_W    = 2 * SUM_W;
  localparam int NX_W    = WIN_W + SAMPLE_W;
  localparam int DEV_W   = NX_W;
  localparam int DEV2_W  = 2 * DEV_W;
  localparam int LHS_W   = DEV2_W + 16;
  localparam int DLO_W   = (NQ_W + 1) / 2;
  localparam int DHI_W   = NQ_W - DLO_W;
  localparam int RHS_W   = NQ_W + SENS2_W;
  localparam int MEM_DEPTH = NUM_METRICS * WINDOW_MAX;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 1'd1;

  localparam logic [WIN_W-1:0]  WINDOW_LEN_RESET  = WIN_W'(32);
  localparam logic [SENS_W-1:0] SENSITIVITY_RESET = SENS_W'(768);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_MUL3 = 6'b001000,
    S_MUL4 = 6'b010000,
    S_DONE = 6'b100000
  } swz_state_e;

endpackage

// ===== design/swz_if.sv =====
// ----------------------------------------------------------------------------
// swz_if: channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface swz_sample_if import swz_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     metric_index;
  logic [SAMPLE_W-1:0] sample_value;
  modport source  (output valid, metric_index, sample_value, input ready);
  modport sink    (input valid, metric_index, sample_value, output ready);
  modport monitor (input valid, ready, metric_index, sample_value);
endinterface

interface swz_result_if;
  logic valid;
  logic ready;
  logic anomaly;
  logic warming;
  modport source  (output valid, anomaly, warming, input ready);
  modport sink    (input valid, anomaly, warming, output ready);
  modport monitor (input valid, ready, anomaly, warming);
endinterface

interface swz_cfg_if import swz_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// ===== design/swz_ram.sv =====
// ----------------------------------------------------------------------------
// swz_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
module swz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sliding_window_zscore_detector_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_zscore_detector_core: per-channel z-score anomaly detector
// Keeps a sample ring per metric channel and flags outliers exactly.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one word per sample (metric_index, sample_value). The
//   block answers each sample with exactly one word on result_o: warming
//   while the channel window is still filling, otherwise anomaly when the
//   population z-score strictly exceeds the sensitivity.
//   cfg_i writes window_len (index 0) or sensitivity (index 1); it is always
//   ready. Writing window_len empties every channel window.
// Timing:
//   A sample passes from acceptance to its result being loaded into the
//   output register through one ring memory read, then a chain of
//   multiply stages (the 61x32 variance product is done as two halves in
//   S_MUL3 and S_MUL4). One sample is in flight at a time, so the block
//   takes no new sample until the last one has left S_DONE.
// Reset and stalls:
//   Reset empties all windows and restores window_len 32, sensitivity 768.
//   The ring memory needs no clearing; only data from filled slots is used. A new
//   sample is accepted while a result still waits; if the receiver stalls,
//   the next result holds in its last stage until the output word is taken.
// ----------------------------------------------------------------------------
module sliding_window_zscore_detector_core import swz_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  swz_sample_if.sink   sample_i,
  swz_result_if.source result_o,
  swz_cfg_if.sink      cfg_i
);

  swz_state_e state_q, state_d;

  logic [WIN_W-1:0]  win_len_q;
  logic [SENS_W-1:0] sens_q;

  logic [WIN_W-1:0] fill_q [NUM_METRICS];
  logic [POS_W-1:0] wpos_q [NUM_METRICS];
  logic [SUM_W-1:0] sum_q  [NUM_METRICS];
  logic [SQ_W-1:0]  sq_q   [NUM_METRICS];

  // Per-item working registers.
  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] x_q;
  logic [POS_W-1:0]    pos_q;
  logic                warm_q;
  logic [SUM_W-1:0]    s_q;
  logic [SQ_W-1:0]     q_q;
  logic [SAMPLE_W-1:0] old_q;
  logic [NQ_W-1:0]     nq_q;
  logic [SS_W-1:0]     ss_q;
  logic [NX_W-1:0]     nx_q;
  logic [SENS2_W-1:0]  sens2_q;
  logic [NQ_W-1:0]     d_q;
  logic                var_pos_q;
  logic [DEV_W-1:0]    dev_q;
  logic [SQ_W-1:0]     old2_q;
  logic [SQ_W-1:0]     x2_q;
  logic [DEV2_W-1:0]   dev2_q;
  logic [RHS_W-1:0]    pp_lo_q;
  logic [RHS_W-1:0]    pp_hi_q;

  logic out_valid_q, anomaly_q, warming_q;

  logic [WIN_W-1:0]    n_eff;
  logic                in_fire, cfg_fire, done_fire, clear_win;
  logic [POS_W-1:0]    rd_pos;
  logic [WIN_W-1:0]    pos_inc;
  logic [POS_W-1:0]    pos_next;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [LHS_W-1:0]    lhs;
  logic [RHS_W-1:0]    rhs;
  logic                anomaly_d;

  always_comb begin
    if (win_len_q == '0) begin
      n_eff = WIN_W'(1);
    end else if (win_len_q > WIN_W'(WINDOW_MAX)) begin
      n_eff = WIN_W'(WINDOW_MAX);
    end else begin
      n_eff = win_len_q;
    end
  end

  assign sample_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign in_fire   = sample_i.valid && sample_i.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign clear_win = cfg_fire && (cfg_i.index == CFG_WINDOW_LEN);
  assign done_fire = (state_q == S_DONE) && (!out_valid_q || result_o.ready);

  assign rd_pos = ({1'b0, wpos_q[sample_i.metric_index]} >= n_eff) ?
                  '0 : wpos_q[sample_i.metric_index];

  assign pos_inc  = {1'b0, pos_q} + WIN_W'(1);
  assign pos_next = (pos_inc >= n_eff) ? '0 : pos_inc[POS_W-1:0];

  swz_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MEM_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (done_fire),
    .waddr_i({ch_q, pos_q}),
    .wdata_i(x_q),
    .re_i   (in_fire),
    .raddr_i({sample_i.metric_index, rd_pos}),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_MUL4;
      S_MUL4: state_d = S_DONE;
      S_DONE: if (done_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Left side is (N*x - S)^2 scaled by 2^16; right side is sens^2 * (N*Q - S^2).
  assign lhs = {dev2_q, 16'd0};
  assign rhs = (pp_hi_q << DLO_W) + pp_lo_q;
  assign anomaly_d = !warm_q && var_pos_q && (RHS_W'(lhs) > rhs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_len_q   <= WINDOW_LEN_RESET;
      sens_q      <= SENSITIVITY_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_METRICS; i++) begin
        fill_q[i] <= '0;
        wpos_q[i] <= '0;
        sum_q[i]  <= '0;
        sq_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        unique case (cfg_i.index)
          CFG_WINDOW_LEN:  win_len_q <= cfg_i.data[WIN_W-1:0];
          CFG_SENSITIVITY: sens_q    <= cfg_i.data[SENS_W-1:0];
          default: ;
        endcase
      end
      if (clear_win) begin
        for (int i = 0; i < NUM_METRICS; i++) begin
          fill_q[i] <= '0;
          wpos_q[i] <= '0;
          sum_q[i]  <= '0;
          sq_q[i]   <= '0;
        end
      end else if (done_fire) begin
        if (warm_q) begin
          fill_q[ch_q] <= fill_q[ch_q] + WIN_W'(1);
        end
        wpos_q[ch_q] <= pos_next;
        sum_q[ch_q]  <= s_q - SUM_W'(old_q) + SUM_W'(x_q);
        sq_q[ch_q]   <= q_q - old2_q + x2_q;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q   <= sample_i.metric_index;
      x_q    <= sample_i.sample_value;
      pos_q  <= rd_pos;
      warm_q <= (fill_q[sample_i.metric_index] < n_eff);
      s_q    <= sum_q[sample_i.metric_index];
      q_q    <= sq_q[sample_i.metric_index];
    end
    if (state_q == S_MUL1) begin
      // A warming slot contributes nothing to remove from the sums.
      old_q   <= warm_q ? '0 : ram_rdata;
      nq_q    <= NQ_W'(n_eff) * NQ_W'(q_q);
      ss_q    <= SS_W'(s_q) * SS_W'(s_q);
      nx_q    <= NX_W'(n_eff) * NX_W'(x_q);
      sens2_q <= SENS2_W'(sens_q) * SENS2_W'(sens_q);
    end
    if (state_q == S_MUL2) begin
      var_pos_q <= nq_q > NQ_W'(ss_q);
      d_q       <= nq_q - NQ_W'(ss_q);
      dev_q     <= (nx_q >= NX_W'(s_q)) ? nx_q - NX_W'(s_q) : NX_W'(s_q) - nx_q;
      old2_q    <= SQ_W'(old_q) * SQ_W'(old_q);
      x2_q      <= SQ_W'(x_q) * SQ_W'(x_q);
    end
    if (state_q == S_MUL3) begin
      dev2_q  <= DEV2_W'(dev_q) * DEV2_W'(dev_q);
      pp_lo_q <= RHS_W'(d_q[DLO_W-1:0]) * RHS_W'(sens2_q);
    end
    if (state_q == S_MUL4) begin
      pp_hi_q <= RHS_W'(d_q[NQ_W-1:DLO_W]) * RHS_W'(sens2_q);
    end
    if (done_fire) begin
      anomaly_q <= anomaly_d;
      warming_q <= warm_q;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.anomaly = anomaly_q;
  assign result_o.warming = warming_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_MUL1)
    else $error("accepted sample did not start the multiply sequence");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished sample");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(anomaly_q && warming_q))
    else $error("result flags both anomaly and warming");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> fill_q[sample_i.metric_index] <= n_eff)
    else $error("channel fill count exceeds window length");

endmodule

// ===== test/swz_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swz_checker: result predictor and scoreboard
// Watches the sample, result and configuration channels, keeps its own copy
// of every channel window and compares each result word with its prediction.
// ----------------------------------------------------------------------------
module swz_checker import swz_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  swz_sample_if.monitor sample_w,
  swz_result_if.monitor result_w,
  swz_cfg_if.monitor    cfg_w,
  output int            fail_count_o,
  output int            pending_o
);

  typedef struct packed {
    logic anomaly;
    logic warming;
  } verdict_t;

  logic [SAMPLE_W-1:0] ring_q [MEM_DEPTH];
  logic [WIN_W-1:0]    fill_q [NUM_METRICS];
  logic [POS_W:0]      wpos_q [NUM_METRICS];
  logic [SUM_W-1:0]    sum_q  [NUM_METRICS];
  logic [SQ_W-1:0]     sq_q   [NUM_METRICS];
  logic [WIN_W-1:0]    win_len_q;
  logic [SENS_W-1:0]   sens_q;
  verdict_t            verdict_queue[$];
  int                  fail_count;
  int                  pending_cnt;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_cnt;

  task automatic clear_windows();
    for (int c = 0; c < NUM_METRICS; c++) begin
      fill_q[c] = '0;
      wpos_q[c] = '0;
      sum_q[c]  = '0;
      sq_q[c]   = '0;
    end
  endtask

  // Exact z-score test of one sample and update of its channel window.
  task automatic score_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] x);
    verdict_t        v;
    logic [255:0]    n, s, q, var_n, dev, lhs, rhs, sens2;
    int unsigned     pos, slot;
    logic [SAMPLE_W-1:0] old;
    v = '0;
    n = (win_len_q == 0) ? 1 : (win_len_q > WINDOW_MAX) ? WINDOW_MAX : win_len_q;
    pos = wpos_q[ch];
    if (pos >= n) pos = 0;
    slot = ch * WINDOW_MAX + pos;
    if (fill_q[ch] < n) begin
      v.warming = 1'b1;
      fill_q[ch] = fill_q[ch] + 1'b1;
    end else begin
      s = sum_q[ch];
      q = sq_q[ch];
      if (n * q > s * s) begin
        var_n = n * q - s * s;
        dev = (n * x >= s) ? n * x - s : s - n * x;
        lhs = (dev * dev) << 16;
        sens2 = sens_q * sens_q;
        rhs = var_n * sens2;
        v.anomaly = lhs > rhs;
      end
      old = ring_q[slot];
      sum_q[ch] = sum_q[ch] - old;
      sq_q[ch]  = sq_q[ch] - SQ_W'(48'(old) * 48'(old));
    end
    ring_q[slot] = x;
    sum_q[ch] = sum_q[ch] + x;
    sq_q[ch]  = sq_q[ch] + SQ_W'(48'(x) * 48'(x));
    wpos_q[ch] = (pos + 1 >= n) ? '0 : (POS_W + 1)'(pos + 1);
    verdict_queue = {verdict_queue, v};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      clear_windows();
      win_len_q = WINDOW_LEN_RESET;
      sens_q = SENSITIVITY_RESET;
      verdict_queue.delete();
      fail_count = 0;
    end else begin
      if (result_w.valid && result_w.ready) begin
        if (verdict_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: anomaly %0b warming %0b",
                     result_w.anomaly, result_w.warming);
        end else begin
          exp_v = verdict_queue.pop_front();
          if (exp_v.anomaly !== result_w.anomaly || exp_v.warming !== result_w.warming) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected anomaly %0b warming %0b, got %0b %0b",
                       exp_v.anomaly, exp_v.warming, result_w.anomaly, result_w.warming);
          end
        end
      end
      if (sample_w.valid && sample_w.ready)
        score_sample(sample_w.metric_index, sample_w.sample_value);
      if (cfg_w.valid && cfg_w.ready) begin
        if (cfg_w.index == CFG_WINDOW_LEN) begin
          win_len_q = WIN_W'(cfg_w.data);
          clear_windows();
        end else if (cfg_w.index == CFG_SENSITIVITY) begin
          sens_q = cfg_w.data;
        end
      end
    end
    pending_cnt = verdict_queue.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: sliding window z-score detector testbench
// Drives directed and random samples through several window and threshold
// settings under random stalls; the checker scores every result word.
// ----------------------------------------------------------------------------
module tb_top import swz_pkg::*; ();

  localparam int IDLE_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   quiet_cycles;

  swz_sample_if sample_w ();
  swz_result_if result_w ();
  swz_cfg_if    cfg_w ();

  sliding_window_zscore_detector_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_w.sink),
    .result_o(result_w.source),
    .cfg_i   (cfg_w.sink)
  );

  swz_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_w    (sample_w.monitor),
    .result_w    (result_w.monitor),
    .cfg_w       (cfg_w.monitor),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Receiver stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_w.ready <= 1'b0;
    end else begin
      result_w.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Nothing accepted for too long ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_w.valid && sample_w.ready) || (result_w.valid && result_w.ready)
        || (cfg_w.valid && cfg_w.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // The word stays valid after acceptance until the next one or an idle
  // cycle replaces it, so valid gets one assignment per clock edge.
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_w.valid        <= 1'b1;
    sample_w.metric_index <= ch;
    sample_w.sample_value <= x;
    do @(posedge clk_i); while (!sample_w.ready);
  endtask

  task automatic drain();
    sample_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= value;
    do @(posedge clk_i); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
  endtask

  // Mostly samples scattered around one of four levels, some wide outliers.
  task automatic random_samples(input int count, input int spread);
    logic [SAMPLE_W-1:0] base;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      base = SAMPLE_W'(24'h100000 + 24'h040000 * $urandom_range(3));
      if (r < 10) send_sample(CH_W'($urandom), SAMPLE_W'($urandom));
      else if (r < 15) send_sample(CH_W'($urandom), base);
      else send_sample(CH_W'($urandom),
                       base + SAMPLE_W'($urandom_range(spread)) - SAMPLE_W'(spread / 2));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    sample_w.valid = 1'b0;
    sample_w.metric_index = '0;
    sample_w.sample_value = '0;
    cfg_w.valid = 1'b0;
    cfg_w.index = CFG_WINDOW_LEN;
    cfg_w.data = '0;
    src_idle_pct = 15;
    snk_idle_pct = 60;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extremes of the sample, a constant window
    // (zero variance) and a clear outlier.
    for (int k = 0; k < 4; k++) send_sample(CH_W'(k), '0);
    send_sample(2'd3, '1);
    write_reg(CFG_WINDOW_LEN, 16'd0);
    send_sample(2'd0, 24'd5);
    send_sample(2'd0, 24'd5);
    send_sample(2'd0, '1);
    write_reg(CFG_WINDOW_LEN, 16'd4);
    for (int k = 0; k < 4; k++) send_sample(2'd1, 24'd1000);
    send_sample(2'd1, 24'd1000);
    send_sample(2'd1, '1);
    send_sample(2'd1, 24'd0);
    write_reg(CFG_SENSITIVITY, 16'd0);
    send_sample(2'd1, 24'd1000);
    write_reg(CFG_SENSITIVITY, 16'hFFFF);
    send_sample(2'd1, '1);
    write_reg(CFG_WINDOW_LEN, 16'h007F);
    send_sample(2'd2, 24'haaaaaa);
    send_sample(2'd2, 24'h555555);

    // Random phases across window and threshold settings.
    write_reg(CFG_WINDOW_LEN, 16'd3);
    write_reg(CFG_SENSITIVITY, 16'd256);
    random_samples(200, 4096);
    src_idle_pct = 60;
    snk_idle_pct = 15;
    write_reg(CFG_WINDOW_LEN, 16'd1);
    random_samples(60, 4096);
    write_reg(CFG_WINDOW_LEN, 16'd8);
    write_reg(CFG_SENSITIVITY, 16'd512);
    random_samples(200, 65536);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(CFG_WINDOW_LEN, 16'd64);
    write_reg(CFG_SENSITIVITY, 16'd300);
    random_samples(340, 1 << 20);

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
